// ===== src/nearest_palette_color_mapper_defines.svh =====
// assertion macros shared by the mapper rtl
`ifndef NEAREST_PALETTE_COLOR_MAPPER_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_DEFINES_SVH

// condition must hold at every active clock edge
`define NPCM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("npcm invariant violated");

// trigger in one cycle implies outcome in the next
`define NPCM_ASSERT_NEXT(label, clk, rst_n, trig, outcome) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
        else $error("npcm sequence violated");

`endif

// ===== src/npcm_pkg.sv =====
`timescale 1ns / 1ps

package npcm_pkg;

    // operation codes carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // slots addressable by a load transaction
    localparam int PALETTE_SLOTS = 16;

    localparam int DIST_W = 18;
    localparam int IDX_W  = 4;

    // largest possible distance is 3 * 255^2, so all ones beats nothing
    localparam logic [DIST_W-1:0] DIST_INIT = '1;

    // transaction moving down the cell chain with its running best match
    typedef struct packed {
        logic              valid;
        logic              is_map;
        logic [IDX_W-1:0]  slot;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
        logic [7:0]        best_red;
        logic [7:0]        best_green;
        logic [7:0]        best_blue;
    } token_t;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] d;
        begin
            d = (a > b) ? {8'd0, a - b} : {8'd0, b - a};
            return d * d;
        end
    endfunction

endpackage

// ===== src/npcm_cell.sv =====
`timescale 1ns / 1ps

module npcm_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [CNT_W-1:0] search_count,
    input  npcm_pkg::token_t tok_in,
    output npcm_pkg::token_t tok_out
);
    import npcm_pkg::*;

    localparam bit          LOADABLE = (INDEX < PALETTE_SLOTS);
    localparam logic [IDX_W-1:0] SLOT = IDX_W'(INDEX % PALETTE_SLOTS);

    logic [23:0]       entry_reg;
    token_t            a_tok_reg;
    logic [23:0]       a_ent_reg;
    logic              a_en_reg;
    logic [15:0]       a_sqr_reg;
    logic [15:0]       a_sqg_reg;
    logic [15:0]       a_sqb_reg;
    token_t            out_tok_reg;
    token_t            out_tok_next;
    logic              load_hit;
    logic              searched;
    logic [DIST_W-1:0] sum_dist;

    // load transaction addressed to this slot
    assign load_hit = LOADABLE && tok_in.valid && (tok_in.is_map == OP_LOAD) &&
                      (tok_in.slot == SLOT);
    assign searched = (CNT_W'(INDEX) < search_count);

    // palette entry held by this cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (advance && load_hit)
        begin
            entry_reg <= {tok_in.red, tok_in.green, tok_in.blue};
        end
    end

    // first stage: channel differences squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tok_reg <= '0;
        end
        else if (advance)
        begin
            a_tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_ent_reg <= entry_reg;
            a_en_reg  <= searched;
            a_sqr_reg <= sq_diff(tok_in.red, entry_reg[23:16]);
            a_sqg_reg <= sq_diff(tok_in.green, entry_reg[15:8]);
            a_sqb_reg <= sq_diff(tok_in.blue, entry_reg[7:0]);
        end
    end

    // second stage: sum and strict compare against running best
    assign sum_dist = DIST_W'(a_sqr_reg) + DIST_W'(a_sqg_reg) + DIST_W'(a_sqb_reg);

    always_comb
    begin
        out_tok_next = a_tok_reg;
        if (a_tok_reg.valid && a_tok_reg.is_map && a_en_reg &&
            (sum_dist < a_tok_reg.best_dist))
        begin
            out_tok_next.best_dist  = sum_dist;
            out_tok_next.best_idx   = SLOT;
            out_tok_next.best_red   = a_ent_reg[23:16];
            out_tok_next.best_green = a_ent_reg[15:8];
            out_tok_next.best_blue  = a_ent_reg[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tok_reg <= '0;
        end
        else if (advance)
        begin
            out_tok_reg <= out_tok_next;
        end
    end

    assign tok_out = out_tok_reg;

endmodule

// ===== src/nearest_palette_color_mapper.sv =====
`timescale 1ns / 1ps
// Nearest palette color mapper, RGB888.
// Slave stream s_*: tuser selects the transaction kind (load palette entry or
// map pixel), tdata carries slot and color. A load writes one palette entry
// and returns nothing; a map returns the nearest entry's color, its index and
// the squared distance on the master stream m_*. Ties go to the lowest index.
// Config channel cfg_*: palette_count, number of entries searched from slot 0
// (0 acts as 1, values above PALETTE_DEPTH act as PALETTE_DEPTH).
// Path from input to m_tvalid: a square register and a sum-and-compare
// register per palette cell, then the output register. Throughput: one
// transaction per cycle while the chain is not stalled, set by the cell chain,
// which holds up to 2 * PALETTE_DEPTH transactions in flight; loads and maps
// keep their order since both travel the same chain.
// Reset clears every palette entry to black and sets palette_count to 16.
// Stall: the chain keeps moving while the output register is free or the
// tail of the chain holds no map result; it freezes, and s_tready drops, only
// when a map result reaches the tail while m_tvalid is high and m_tready low.
module nearest_palette_color_mapper #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // cfg_data: palette_count [4:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: entry_index [3:0], red [11:4], green [19:12], blue [27:20]
    input  logic [31:0] s_tdata,
    // s_tuser: operation [0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: nearest_red [7:0], nearest_green [15:8], nearest_blue [23:16],
    //          nearest_index [27:24], squared_distance [45:28]
    output logic [47:0] m_tdata
);
    import npcm_pkg::*;

    `include "nearest_palette_color_mapper_defines.svh"

    localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam int STAGES = PALETTE_DEPTH;

    logic [4:0]       palette_count_reg;
    logic [CNT_W-1:0] search_count;
    logic [CMP_W-1:0] count_ext;
    logic             advance;
    token_t           chain [0:STAGES];
    token_t           tail;
    logic             tail_map;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [47:0]      m_tdata_reg;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            palette_count_reg <= cfg_data;
        end
    end

    // clamp search count to 1 .. PALETTE_DEPTH
    assign count_ext = CMP_W'(palette_count_reg);

    always_comb
    begin
        if (count_ext == '0)
        begin
            search_count = CNT_W'(1);
        end
        else if (count_ext > CMP_W'(PALETTE_DEPTH))
        begin
            search_count = CNT_W'(PALETTE_DEPTH);
        end
        else
        begin
            search_count = CNT_W'(count_ext);
        end
    end

    // chain advance control
    assign tail     = chain[STAGES];
    assign tail_map = tail.valid && tail.is_map;
    assign advance  = !m_tvalid_reg || m_tready || !tail_map;
    assign s_tready = advance;

    // transaction entering the chain
    always_comb
    begin
        chain[0]            = '0;
        chain[0].valid      = s_tvalid;
        chain[0].is_map     = (s_tuser == OP_MAP);
        chain[0].slot       = s_tdata[3:0];
        chain[0].red        = s_tdata[11:4];
        chain[0].green      = s_tdata[19:12];
        chain[0].blue       = s_tdata[27:20];
        chain[0].best_dist  = DIST_INIT;
    end

    // one cell per palette entry
    genvar gi;
    generate
        for (gi = 0; gi < STAGES; gi++)
        begin : g_cell
            npcm_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .advance      (advance),
                .search_count (search_count),
                .tok_in       (chain[gi]),
                .tok_out      (chain[gi+1])
            );
        end
    endgenerate

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (advance && tail_map)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_map)
        begin
            m_tdata_reg <= {2'b00, tail.best_dist, tail.best_idx,
                            tail.best_blue, tail.best_green, tail.best_red};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `NPCM_ASSERT_NEXT(a_count_hold, clk, rst_n, !(cfg_valid && cfg_ready), $stable(palette_count_reg))
    `NPCM_ASSERT_ALWAYS(a_dist_range, clk, rst_n, !m_tvalid || (m_tdata[45:28] <= 18'd195075))
    `NPCM_ASSERT_NEXT(a_tail_lands, clk, rst_n, advance && tail_map, m_tvalid)

endmodule
